// ===== hw/rtl/canls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CAN link supervisor package
// Shared types, state codes, register map and constants for the CAN link
// supervisor core.
// ----------------------------------------------------------------------------
package canls_pkg;

   // Link state codes.
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_INIT      = 2'd0;
   localparam mode_type MODE_HANDSHAKE = 2'd1;
   localparam mode_type MODE_READY     = 2'd2;
   localparam mode_type MODE_ERROR     = 2'd3;

   // Item function codes.
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   // Register map: word index within the configuration space.
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_TX_PERIOD      = 2'd0;
   localparam csr_index_type CSR_HANDSHAKE_LIM  = 2'd1;
   localparam csr_index_type CSR_RX_FRESH_LIM   = 2'd2;
   localparam csr_index_type CSR_WATCHDOG_INTVL = 2'd3;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register reset values.
   localparam logic [15:0] TX_PERIOD_RESET      = 16'd10;
   localparam logic [15:0] HANDSHAKE_LIM_RESET  = 16'd1000;
   localparam logic [15:0] RX_FRESH_LIM_RESET   = 16'd200;
   localparam logic [15:0] WATCHDOG_INTVL_RESET = 16'd50;

   // A value is a multiple of 100 when its two low bits are clear and the
   // upper thirty bits are a multiple of 25. The latter is tested by
   // multiplying with the inverse of 25 modulo 2^32 and comparing the
   // wrapped product against the largest quotient of 25 that fits.
   localparam logic [31:0] INV_25       = 32'hC28F_5C29;
   localparam logic [31:0] DIV_25_LIMIT = 32'h0A3D_70A3;

   // One input beat.
   typedef struct packed {
      logic        func;
      logic [31:0] now_ms;
      logic        init_ok;
      logic [31:0] rx_age_ms;
      logic        rx_lost;
      logic        bus_off;
      logic        tx_data_present;
   } req_item_type;

endpackage : canls_pkg
`default_nettype wire

// ===== hw/rtl/can_link_supervisor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CAN link supervisor core
// Steps the link state machine (init, handshake, ready, error) once per
// request beat and schedules transmit slots and watchdog kicks.
// ----------------------------------------------------------------------------
// The core takes one request beat per clock cycle unless stalled and returns
// exactly one response beat for each, in order. A beat passes through three
// registers: the request register, a register holding the multiple-of-100
// test on the time stamp (one 32-bit multiply), and the response register.
// The link state, time stamps and fault count are held in one stage and
// updated in the cycle a beat moves into the response register, so the next
// beat sees them at once and the sustained rate is one beat per cycle while
// the response side does not stall. When the response side stalls, up to
// three beats are held inside before the request side is stalled. The four
// timing registers are to be written over the APB-style port while no beat
// is in flight, by the user; the core itself does not enforce this.
module can_link_supervisor_core (
   input  wire logic        clock,
   input  wire logic        reset,

   // Request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_init_ok,
   input  wire logic [31:0] req_rx_age_ms,
   input  wire logic        req_rx_lost,
   input  wire logic        req_bus_off,
   input  wire logic        req_tx_data_present,

   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_link_state,
   output logic             rsp_init_attempt,
   output logic             rsp_recover_request,
   output logic             rsp_send_frames,
   output logic             rsp_watchdog_kick,
   output logic [15:0]      rsp_time_to_next_tx,
   output logic [31:0]      rsp_fault_count,

   // Configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [canls_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [canls_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [canls_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import canls_pkg::*;

   // Configuration registers
   logic [15:0]   tx_period_ff;
   logic [15:0]   handshake_lim_ff;
   logic [15:0]   rx_fresh_lim_ff;
   logic [15:0]   watchdog_intvl_ff;
   logic          csr_write;
   csr_index_type csr_index;

   // Pipeline control
   logic          out_free;
   logic          s1_free;
   logic          s0_free;
   logic          req_fire;
   logic          s0_fire;
   logic          s1_fire;
   logic          s0_valid_ff;
   logic          s0_valid_in;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // Pipeline payload
   req_item_type  req_item;
   req_item_type  s0_item_ff;
   req_item_type  s1_item_ff;
   logic          s1_hundred_ff;
   logic [31:0]   s0_div_prod;
   logic          s0_hundred;

   // Link state
   mode_type      mode_ff;
   mode_type      mode_in;
   logic [31:0]   last_tx_ff;
   logic [31:0]   last_tx_in;
   logic [31:0]   last_kick_ff;
   logic [31:0]   last_kick_in;
   logic [31:0]   hs_start_ff;
   logic [31:0]   hs_start_in;
   logic [31:0]   tally_ff;
   logic [31:0]   tally_in;

   // State step terms
   logic          stamps_set;
   logic          init_attempt;
   logic          recover;
   logic [31:0]   hs_elapsed;
   logic          hs_expired;
   logic          rx_fresh;
   logic [31:0]   tx_elapsed_raw;
   logic [31:0]   tx_elapsed;
   logic          tx_slot;
   logic [31:0]   kick_elapsed;
   logic          kick_due;
   logic          send;
   logic [31:0]   tx_elapsed_after;
   logic [15:0]   ttn;

   // Response registers
   mode_type      rsp_state_ff;
   logic          rsp_init_ff;
   logic          rsp_recover_ff;
   logic          rsp_send_ff;
   logic          rsp_kick_ff;
   logic [15:0]   rsp_ttn_ff;
   logic [31:0]   rsp_fault_ff;

   // ------------------------------------------------------------------------
   // Configuration port: writes complete in the access cycle, no wait states.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_period_ff      <= TX_PERIOD_RESET;
         handshake_lim_ff  <= HANDSHAKE_LIM_RESET;
         rx_fresh_lim_ff   <= RX_FRESH_LIM_RESET;
         watchdog_intvl_ff <= WATCHDOG_INTVL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TX_PERIOD:      tx_period_ff      <= csr_pwdata[15:0];
            CSR_HANDSHAKE_LIM:  handshake_lim_ff  <= csr_pwdata[15:0];
            CSR_RX_FRESH_LIM:   rx_fresh_lim_ff   <= csr_pwdata[15:0];
            CSR_WATCHDOG_INTVL: watchdog_intvl_ff <= csr_pwdata[15:0];
            default:            tx_period_ff      <= tx_period_ff;
         endcase
      end
   end

   // Read data follows the address.
   always_comb begin
      unique case (csr_index)
         CSR_TX_PERIOD:      csr_prdata = {16'd0, tx_period_ff};
         CSR_HANDSHAKE_LIM:  csr_prdata = {16'd0, handshake_lim_ff};
         CSR_RX_FRESH_LIM:   csr_prdata = {16'd0, rx_fresh_lim_ff};
         CSR_WATCHDOG_INTVL: csr_prdata = {16'd0, watchdog_intvl_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flow control: each stage moves on when the stage after it is free.
   // ------------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   assign s0_fire   = s0_valid_ff && s1_free;
   assign s0_free   = !s0_valid_ff || s1_free;
   assign req_ready = s0_free;
   assign req_fire  = req_valid && s0_free;

   assign s0_valid_in  = req_fire || (s0_valid_ff && !s0_fire);
   assign s1_valid_in  = s0_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Request register and the multiple-of-100 test on the time stamp.
   // ------------------------------------------------------------------------
   assign req_item = '{
      func:            req_func,
      now_ms:          req_now_ms,
      init_ok:         req_init_ok,
      rx_age_ms:       req_rx_age_ms,
      rx_lost:         req_rx_lost,
      bus_off:         req_bus_off,
      tx_data_present: req_tx_data_present
   };

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_item_ff <= req_item;
      end
   end

   assign s0_div_prod = 32'({2'b00, s0_item_ff.now_ms[31:2]} * INV_25);
   assign s0_hundred  = (s0_item_ff.now_ms[1:0] == 2'b00) && (s0_div_prod <= DIV_25_LIMIT);

   always_ff @(posedge clock) begin
      if (s0_fire) begin
         s1_item_ff    <= s0_item_ff;
         s1_hundred_ff <= s0_hundred;
      end
   end

   // ------------------------------------------------------------------------
   // Link state machine step.
   // ------------------------------------------------------------------------
   assign hs_elapsed = s1_item_ff.now_ms - hs_start_ff;
   assign hs_expired = hs_elapsed > {16'd0, handshake_lim_ff};
   assign rx_fresh   = s1_item_ff.rx_age_ms < {16'd0, rx_fresh_lim_ff};

   always_comb begin
      mode_in      = mode_ff;
      hs_start_in  = hs_start_ff;
      tally_in     = tally_ff;
      stamps_set   = 1'b0;
      init_attempt = 1'b0;
      recover      = 1'b0;
      if (s1_item_ff.func == FUNC_RESTART) begin
         mode_in = MODE_INIT;
         recover = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_INIT: begin
               init_attempt = 1'b1;
               if (s1_item_ff.init_ok) begin
                  mode_in     = MODE_HANDSHAKE;
                  hs_start_in = s1_item_ff.now_ms;
                  stamps_set  = 1'b1;
               end else begin
                  mode_in = MODE_ERROR;
               end
            end
            MODE_HANDSHAKE: begin
               if (hs_expired) begin
                  mode_in = MODE_ERROR;
               end else if (rx_fresh) begin
                  mode_in = MODE_READY;
               end
            end
            MODE_READY: begin
               if (s1_item_ff.rx_lost) begin
                  mode_in  = MODE_ERROR;
                  tally_in = tally_ff + 32'd1;
               end else if (s1_item_ff.bus_off) begin
                  mode_in = MODE_ERROR;
               end
            end
            MODE_ERROR: begin
               // Recovery is only tried on whole hundreds of milliseconds.
               if (s1_hundred_ff) begin
                  recover      = 1'b1;
                  init_attempt = 1'b1;
                  if (s1_item_ff.init_ok) begin
                     mode_in     = MODE_HANDSHAKE;
                     hs_start_in = s1_item_ff.now_ms;
                  end
               end
            end
            default: begin
               mode_in = MODE_INIT;
            end
         endcase
      end
   end

   // Transmit slot: a successful init restamps to now, so elapsed is zero.
   assign tx_elapsed_raw = s1_item_ff.now_ms - last_tx_ff;
   assign tx_elapsed     = stamps_set ? 32'd0 : tx_elapsed_raw;
   assign tx_slot        = (s1_item_ff.func == FUNC_TICK) && s1_item_ff.tx_data_present
                           && (tx_elapsed >= {16'd0, tx_period_ff});
   assign send           = tx_slot && (mode_in == MODE_READY);
   assign last_tx_in     = (tx_slot || stamps_set) ? s1_item_ff.now_ms : last_tx_ff;

   // Watchdog kick.
   assign kick_elapsed = stamps_set ? 32'd0 : (s1_item_ff.now_ms - last_kick_ff);
   assign kick_due     = (s1_item_ff.func == FUNC_TICK)
                         && (kick_elapsed >= {16'd0, watchdog_intvl_ff});
   assign last_kick_in = (kick_due || stamps_set) ? s1_item_ff.now_ms : last_kick_ff;

   // Time to the next slot, measured from the updated transmit stamp.
   assign tx_elapsed_after = (tx_slot || stamps_set) ? 32'd0 : tx_elapsed_raw;
   assign ttn = (tx_elapsed_after >= {16'd0, tx_period_ff}) ? 16'd0
                : (tx_period_ff - tx_elapsed_after[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         last_tx_ff   <= '0;
         last_kick_ff <= '0;
         hs_start_ff  <= '0;
         tally_ff     <= '0;
      end else if (s1_fire) begin
         mode_ff      <= mode_in;
         last_tx_ff   <= last_tx_in;
         last_kick_ff <= last_kick_in;
         hs_start_ff  <= hs_start_in;
         tally_ff     <= tally_in;
      end
   end

   // ------------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_state_ff   <= mode_in;
         rsp_init_ff    <= init_attempt;
         rsp_recover_ff <= recover;
         rsp_send_ff    <= send;
         rsp_kick_ff    <= kick_due;
         rsp_ttn_ff     <= ttn;
         rsp_fault_ff   <= tally_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_link_state      = rsp_state_ff;
   assign rsp_init_attempt    = rsp_init_ff;
   assign rsp_recover_request = rsp_recover_ff;
   assign rsp_send_frames     = rsp_send_ff;
   assign rsp_watchdog_kick   = rsp_kick_ff;
   assign rsp_time_to_next_tx = rsp_ttn_ff;
   assign rsp_fault_count     = rsp_fault_ff;

`ifndef SYNTH
   // Frames are only sent from the ready state.
   a_send_only_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_frames |-> rsp_link_state == MODE_READY)
      else $error("send_frames outside ready state");

   // An init attempt always leaves the link in handshake or error.
   a_init_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_init_attempt |->
         (rsp_link_state == MODE_HANDSHAKE || rsp_link_state == MODE_ERROR))
      else $error("init attempt left link in unexpected state");

   // The fault count advances by at most one per beat.
   a_tally_step: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (tally_ff == $past(tally_ff) || tally_ff == $past(tally_ff) + 32'd1))
      else $error("fault count jumped");

   // The time to the next slot never exceeds the transmit period.
   a_ttn_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_time_to_next_tx <= tx_period_ff)
      else $error("time to next slot exceeds period");
`endif

endmodule : can_link_supervisor_core
`default_nettype wire

// ===== verif/canls_link_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN link supervisor checker
// Watches the request, response and configuration ports of the supervisor
// core. It keeps its own copy of the timing registers and link state,
// predicts the status of every accepted request beat and compares each
// response beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module canls_link_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,

   // Request channel
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire canls_pkg::req_item_type             req_beat,

   // Response channel
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [1:0]                          rsp_link_state,
   input  wire logic                                rsp_init_attempt,
   input  wire logic                                rsp_recover_request,
   input  wire logic                                rsp_send_frames,
   input  wire logic                                rsp_watchdog_kick,
   input  wire logic [15:0]                         rsp_time_to_next_tx,
   input  wire logic [31:0]                         rsp_fault_count,

   // Configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic                                csr_pready,
   input  wire logic [canls_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [canls_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,

   // Status towards the testbench top
   output logic [31:0]                              pending_count,
   output logic [31:0]                              mismatch_total
);
   import canls_pkg::*;

   localparam logic [31:0] RECOVER_SPACING = 32'd100;

   // Status of the link after one beat, as the core reports it.
   typedef struct packed {
      logic [1:0]  link_state;
      logic        init_attempt;
      logic        recover_request;
      logic        send_frames;
      logic        watchdog_kick;
      logic [15:0] time_to_next_tx;
      logic [31:0] fault_count;
   } link_status_type;

   // Shadow copy of the timing registers.
   logic [15:0] tx_period;
   logic [15:0] handshake_limit;
   logic [15:0] rx_fresh_limit;
   logic [15:0] watchdog_interval;

   // Shadow copy of the link state.
   mode_type    link_mode;
   logic [31:0] tx_stamp;
   logic [31:0] kick_stamp;
   logic [31:0] handshake_start;
   logic [31:0] loss_tally;

   link_status_type link_status_q[$];
   link_status_type want;
   int unsigned     mismatches = 0;

   initial pending_count = '0;
   assign mismatch_total = mismatches;

   // Advances the shadow link state by one beat and returns its status.
   function automatic link_status_type step_supervisor(input req_item_type beat);
      link_status_type st;
      logic [31:0]     since;
      st = '0;
      if (beat.func == FUNC_RESTART) begin
         link_mode          = MODE_INIT;
         st.recover_request = 1'b1;
      end else begin
         case (link_mode)
            MODE_INIT: begin
               st.init_attempt = 1'b1;
               if (beat.init_ok) begin
                  link_mode       = MODE_HANDSHAKE;
                  handshake_start = beat.now_ms;
                  tx_stamp        = beat.now_ms;
                  kick_stamp      = beat.now_ms;
               end else begin
                  link_mode = MODE_ERROR;
               end
            end
            MODE_HANDSHAKE: begin
               since = beat.now_ms - handshake_start;
               if (since > {16'd0, handshake_limit}) begin
                  link_mode = MODE_ERROR;
               end else if (beat.rx_age_ms < {16'd0, rx_fresh_limit}) begin
                  link_mode = MODE_READY;
               end
            end
            MODE_READY: begin
               if (beat.rx_lost) begin
                  link_mode  = MODE_ERROR;
                  loss_tally = loss_tally + 32'd1;
               end else if (beat.bus_off) begin
                  link_mode = MODE_ERROR;
               end
            end
            default: begin
               // Recovery is only tried on whole hundreds of milliseconds.
               if (beat.now_ms % RECOVER_SPACING == 32'd0) begin
                  st.recover_request = 1'b1;
                  st.init_attempt    = 1'b1;
                  if (beat.init_ok) begin
                     link_mode       = MODE_HANDSHAKE;
                     handshake_start = beat.now_ms;
                  end
               end
            end
         endcase

         // Transmit slot, then watchdog kick, both on wrapping differences.
         since = beat.now_ms - tx_stamp;
         if (since >= {16'd0, tx_period} && beat.tx_data_present) begin
            if (link_mode == MODE_READY) begin
               st.send_frames = 1'b1;
            end
            tx_stamp = beat.now_ms;
         end
         since = beat.now_ms - kick_stamp;
         if (since >= {16'd0, watchdog_interval}) begin
            kick_stamp       = beat.now_ms;
            st.watchdog_kick = 1'b1;
         end
      end

      since = beat.now_ms - tx_stamp;
      st.time_to_next_tx = (since >= {16'd0, tx_period}) ? 16'd0 : tx_period - since[15:0];
      st.link_state      = link_mode;
      st.fault_count     = loss_tally;
      return st;
   endfunction

   task automatic check_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
                  act_val);
         mismatches++;
      end
   endtask

   // Everything is sampled at the rising edge, before the core updates.
   always @(posedge clock) begin
      if (reset) begin
         tx_period         = TX_PERIOD_RESET;
         handshake_limit   = HANDSHAKE_LIM_RESET;
         rx_fresh_limit    = RX_FRESH_LIM_RESET;
         watchdog_interval = WATCHDOG_INTVL_RESET;
         link_mode         = MODE_INIT;
         tx_stamp          = '0;
         kick_stamp        = '0;
         handshake_start   = '0;
         loss_tally        = '0;
         link_status_q.delete();
      end else begin
         // Response beat against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (link_status_q.size() == 0) begin
               $display("%0t: response beat with none outstanding, expected nothing, %s %0h",
                        $time, "actual state", rsp_link_state);
               mismatches++;
            end else begin
               want = link_status_q.pop_front();
               check_field("link_state", 32'(want.link_state), 32'(rsp_link_state));
               check_field("init_attempt", 32'(want.init_attempt), 32'(rsp_init_attempt));
               check_field("recover_request", 32'(want.recover_request),
                           32'(rsp_recover_request));
               check_field("send_frames", 32'(want.send_frames), 32'(rsp_send_frames));
               check_field("watchdog_kick", 32'(want.watchdog_kick),
                           32'(rsp_watchdog_kick));
               check_field("time_to_next_tx", 32'(want.time_to_next_tx),
                           32'(rsp_time_to_next_tx));
               check_field("fault_count", want.fault_count, rsp_fault_count);
            end
         end

         // Register writes keep the shadow timing registers in step.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]))
               CSR_TX_PERIOD:      tx_period         = csr_pwdata[15:0];
               CSR_HANDSHAKE_LIM:  handshake_limit   = csr_pwdata[15:0];
               CSR_RX_FRESH_LIM:   rx_fresh_limit    = csr_pwdata[15:0];
               CSR_WATCHDOG_INTVL: watchdog_interval = csr_pwdata[15:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            link_status_q.push_back(step_supervisor(req_beat));
         end
      end
      pending_count <= 32'(link_status_q.size());
   end

endmodule : canls_link_checker

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN link supervisor core testbench
// Drives request beats and timing register writes into the core, with
// random gaps on the request side and random stalls on the response side.
// A directed sequence walks the link state machine through its transitions
// and corner cases; random phases then run realistic time lines mixed with
// noise under several register settings. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
   import canls_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned PHASE_BEATS   = 140;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_beat  = '0;

   // Response channel
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [1:0]   rsp_link_state;
   logic         rsp_init_attempt;
   logic         rsp_recover_request;
   logic         rsp_send_frames;
   logic         rsp_watchdog_kick;
   logic [15:0]  rsp_time_to_next_tx;
   logic [31:0]  rsp_fault_count;

   // Configuration port
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   logic [31:0] pending_count;
   logic [31:0] mismatch_total;

   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct   = 0;
   int unsigned cycle_count     = 0;
   logic [31:0] sim_now         = '0;

   can_link_supervisor_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_beat.func),
      .req_now_ms          (req_beat.now_ms),
      .req_init_ok         (req_beat.init_ok),
      .req_rx_age_ms       (req_beat.rx_age_ms),
      .req_rx_lost         (req_beat.rx_lost),
      .req_bus_off         (req_beat.bus_off),
      .req_tx_data_present (req_beat.tx_data_present),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_link_state      (rsp_link_state),
      .rsp_init_attempt    (rsp_init_attempt),
      .rsp_recover_request (rsp_recover_request),
      .rsp_send_frames     (rsp_send_frames),
      .rsp_watchdog_kick   (rsp_watchdog_kick),
      .rsp_time_to_next_tx (rsp_time_to_next_tx),
      .rsp_fault_count     (rsp_fault_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   canls_link_checker link_chk (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_beat            (req_beat),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_link_state      (rsp_link_state),
      .rsp_init_attempt    (rsp_init_attempt),
      .rsp_recover_request (rsp_recover_request),
      .rsp_send_frames     (rsp_send_frames),
      .rsp_watchdog_kick   (rsp_watchdog_kick),
      .rsp_time_to_next_tx (rsp_time_to_next_tx),
      .rsp_fault_count     (rsp_fault_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_pready          (csr_pready),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .pending_count       (pending_count),
      .mismatch_total      (mismatch_total)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The response side stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("can_link_supervisor_core regression: fail");
         $finish;
      end
   end

   function automatic req_item_type make_beat(input logic func, input logic [31:0] now,
                                              input logic ok, input logic [31:0] age,
                                              input logic lost, input logic off,
                                              input logic txd);
      req_item_type b;
      b.func            = func;
      b.now_ms          = now;
      b.init_ok         = ok;
      b.rx_age_ms       = age;
      b.rx_lost         = lost;
      b.bus_off         = off;
      b.tx_data_present = txd;
      return b;
   endfunction

   // Presents one beat after an optional random gap and holds it until taken.
   task automatic send_beat(input req_item_type b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Holds the request side off until every predicted beat has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Rewrites all four timing registers once the core is idle.
   task automatic set_timing(input logic [15:0] tx, input logic [15:0] hs,
                             input logic [15:0] rx, input logic [15:0] wd);
      wait_all_results();
      csr_write(CSR_TX_PERIOD, tx);
      csr_write(CSR_HANDSHAKE_LIM, hs);
      csr_write(CSR_RX_FRESH_LIM, rx);
      csr_write(CSR_WATCHDOG_INTVL, wd);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Walks the state machine through each transition and the edge cases.
   task automatic run_directed();
      // Failed init, then recovery on a whole hundred.
      send_beat(make_beat(FUNC_TICK, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_TICK, 32'd100, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      // Partner not heard, then heard just under the freshness limit.
      send_beat(make_beat(FUNC_TICK, 32'd150, 1'b0, 32'd500, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_TICK, 32'd160, 1'b0, 32'd199, 1'b0, 1'b0, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'd165, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'd170, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1));
      // Receive loss takes precedence over bus-off and counts a fault.
      send_beat(make_beat(FUNC_TICK, 32'd171, 1'b0, 32'd0, 1'b1, 1'b1, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'd250, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_TICK, 32'd300, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0));
      // Restart, then a handshake that ends exactly at and just past the limit.
      send_beat(make_beat(FUNC_RESTART, 32'd305, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'd306, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_TICK, 32'd1306, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_TICK, 32'd1307, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      // Handshake across the wrap of the millisecond clock.
      send_beat(make_beat(FUNC_RESTART, 32'hFFFF_FFF0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1,
                          1'b1));
      send_beat(make_beat(FUNC_TICK, 32'hFFFF_FFF0, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_TICK, 32'h0000_0005, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'h0000_0006, 1'b0, 32'd0, 1'b0, 1'b1, 1'b1));
      // All-ones beat in error, then the last whole hundred before the wrap.
      send_beat(make_beat(FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'hFFFF_FFA0, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
      // Zero period and interval: every tick is a kick, and a slot when it has data.
      set_timing(16'd0, HANDSHAKE_LIM_RESET, RX_FRESH_LIM_RESET, 16'd0);
      send_beat(make_beat(FUNC_TICK, 32'd500, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'd500, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1));
      send_beat(make_beat(FUNC_TICK, 32'd501, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(FUNC_RESTART, 32'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
   endtask

   // Mostly a plausible advancing time line with random status, some noise.
   task automatic run_random(input int unsigned count);
      req_item_type b;
      int unsigned  pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            b = make_beat(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)), $urandom,
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
         end else begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               sim_now = sim_now - (sim_now % 32'd100) + 32'd100;
            end else if (pick < 11) begin
               sim_now = sim_now + $urandom_range(0, 70000);
            end else begin
               sim_now = sim_now + $urandom_range(0, 40);
            end
            b.func    = ($urandom_range(99) < 3) ? FUNC_RESTART : FUNC_TICK;
            b.now_ms  = sim_now;
            b.init_ok = ($urandom_range(99) < 85);
            pick = $urandom_range(99);
            if (pick < 50) begin
               b.rx_age_ms = $urandom_range(0, 300);
            end else if (pick < 80) begin
               b.rx_age_ms = $urandom_range(0, 70000);
            end else begin
               b.rx_age_ms = $urandom;
            end
            b.rx_lost         = ($urandom_range(99) < 8);
            b.bus_off         = ($urandom_range(99) < 5);
            b.tx_data_present = ($urandom_range(99) < 70);
         end
         send_beat(b);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Reset values, no idling.
      set_timing(TX_PERIOD_RESET, HANDSHAKE_LIM_RESET, RX_FRESH_LIM_RESET,
                 WATCHDOG_INTVL_RESET);
      sim_now = $urandom;
      run_random(PHASE_BEATS);

      // Largest values, sender idling; time line starts just before the wrap.
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      sender_idle_pct = 46;
      sim_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      run_random(PHASE_BEATS);

      // Smallest values, receiver stalling.
      set_timing(16'd1, 16'd0, 16'd0, 16'd1);
      sender_idle_pct = 0;
      rsp_stall_pct   = 46;
      sim_now = $urandom;
      run_random(PHASE_BEATS);

      // Moderate random values, light idling on both sides.
      set_timing(16'($urandom_range(1, 60)), 16'($urandom_range(50, 1500)),
                 16'($urandom_range(20, 300)), 16'($urandom_range(1, 100)));
      sender_idle_pct = 7;
      rsp_stall_pct   = 7;
      sim_now = $urandom;
      run_random(PHASE_BEATS);

      // Another random setting, back to full rate.
      set_timing(16'($urandom_range(1, 200)), 16'($urandom_range(0, 4000)),
                 16'($urandom_range(0, 600)), 16'($urandom_range(1, 300)));
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      sim_now = $urandom;
      run_random(PHASE_BEATS);

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_total == 0) begin
         $display("can_link_supervisor_core regression: pass");
      end else begin
         $display("can_link_supervisor_core regression: fail");
      end
      $finish;
   end

endmodule : tb_top
